[design/mcsag_pkg.sv]
package mcsag_pkg;

	// Fixed data widths.
	localparam int ADC_BITS   = 16;
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int CUR_W      = 26;
	localparam int ALPHA_W    = 16;
	localparam int PP_W       = 5;
	localparam int STEP_IN_W  = 16;

	// Derived datapath widths.
	localparam int DIFF_W = ADC_BITS + 1;
	localparam int SUM_W  = DIFF_W + 2;
	localparam int X_W    = CUR_W + 1;
	localparam int ERR_W  = CUR_W + 2;
	localparam int PROD_W = ERR_W + ALPHA_W + 1;
	localparam int RND_W  = PROD_W - ALPHA_W;
	localparam int ACC_W  = RND_W + 1;

	// Division by three through a reciprocal. The sum is biased to a positive
	// value, divided, and the bias is removed again afterwards.
	localparam int DIV_W    = SUM_W + 1;
	localparam int DIV_K    = DIV_W + 1;
	localparam int DIV_M    = (2 ** DIV_K) / 3 + 1;
	localparam int DIV_BIAS = 3 * (2 ** (SUM_W - 1));
	localparam int Q_BIAS   = 2 ** (SUM_W - 1);
	localparam int ZS_MUL   = (2 ** FRAC_BITS - 1) / 3;

	// Phase bookkeeping.
	localparam int NUM_PH = 3;
	localparam int PH_W   = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_U  = 3'd0,
		CFG_OFFSET_V  = 3'd1,
		CFG_OFFSET_W  = 3'd2,
		CFG_ALPHA     = 3'd3,
		CFG_OL_STEP   = 3'd4,
		CFG_POLE_PAIR = 3'd5
	} cfg_idx_t;

	// Register reset values.
	localparam logic [ADC_BITS-1:0]   OFFSET_RST  = 16'd32768;
	localparam logic [ALPHA_W-1:0]    ALPHA_RST   = 16'd6554;
	localparam logic [STEP_IN_W-1:0]  OL_STEP_RST = 16'd82;
	localparam logic [PP_W-1:0]       PP_RST      = 5'd4;

	typedef struct packed {
		logic [ADC_BITS-1:0]  offset_u;
		logic [ADC_BITS-1:0]  offset_v;
		logic [ADC_BITS-1:0]  offset_w;
		logic [ALPHA_W-1:0]   alpha;
		logic [STEP_IN_W-1:0] ol_step;
		logic [PP_W-1:0]      pole_pairs;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            load;
		logic            sum_en;
		logic            zseq_en;
		logic            mul_en;
		logic            acc_en;
		logic            out_load;
		logic [PH_W-1:0] sel;
	} ctrl_cmd_t;

endpackage

[design/motor_current_sense_angle_gen_unit.sv]
// Three-phase current conditioning with an angle integrator. Each request
// carries three raw ADC samples, the angle mode and a Hall angle step; the
// block subtracts the calibrated offsets, removes the zero-sequence mean,
// low-pass filters each phase in ADC counts with 8 fraction bits (saturated
// to 26 bits signed) and returns the electrical angle in 1/65536 turn. A
// request passes through capture, sum, and zero-sequence removal, then a
// multiply and an accumulate per phase on the single shared filter
// multiplier, then the load of the output register; the next request is
// taken only after that load. A result waits in the output register while
// the next request is accepted and processed. Configuration writes are to
// be made only while the block is idle; the block itself does not enforce
// this.
module motor_current_sense_angle_gen_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_u,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_v,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_w,
	input  logic                                   open_loop_mode,
	input  logic [mcsag_pkg::STEP_IN_W-1:0]        hall_angle_step,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_u,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_v,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_w,
	output logic [mcsag_pkg::ANGLE_BITS-1:0]       electrical_angle,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mcsag_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mcsag_pkg::CFG_DATA_W-1:0]       cfg_data
);

	mcsag_pkg::cfg_t      cfg;
	mcsag_pkg::ctrl_cmd_t cmd;

	// Configuration registers.
	mcsag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer and handshakes.
	mcsag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	mcsag_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg              (cfg),
		.sample_u         (sample_u),
		.sample_v         (sample_v),
		.sample_w         (sample_w),
		.open_loop_mode   (open_loop_mode),
		.hall_angle_step  (hall_angle_step),
		.current_u        (current_u),
		.current_v        (current_v),
		.current_w        (current_w),
		.electrical_angle (electrical_angle)
	);

endmodule

[design/mcsag_cfg.sv]
module mcsag_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mcsag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcsag_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mcsag_pkg::cfg_t                    cfg
);

	mcsag_pkg::cfg_t cfg_q;

	// Writes are always taken, so the port never stalls.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file; unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_u   <= mcsag_pkg::OFFSET_RST;
			cfg_q.offset_v   <= mcsag_pkg::OFFSET_RST;
			cfg_q.offset_w   <= mcsag_pkg::OFFSET_RST;
			cfg_q.alpha      <= mcsag_pkg::ALPHA_RST;
			cfg_q.ol_step    <= mcsag_pkg::OL_STEP_RST;
			cfg_q.pole_pairs <= mcsag_pkg::PP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mcsag_pkg::CFG_OFFSET_U: begin
					cfg_q.offset_u <= cfg_data[mcsag_pkg::ADC_BITS-1:0];
				end
				mcsag_pkg::CFG_OFFSET_V: begin
					cfg_q.offset_v <= cfg_data[mcsag_pkg::ADC_BITS-1:0];
				end
				mcsag_pkg::CFG_OFFSET_W: begin
					cfg_q.offset_w <= cfg_data[mcsag_pkg::ADC_BITS-1:0];
				end
				mcsag_pkg::CFG_ALPHA: begin
					cfg_q.alpha <= cfg_data[mcsag_pkg::ALPHA_W-1:0];
				end
				mcsag_pkg::CFG_OL_STEP: begin
					cfg_q.ol_step <= cfg_data[mcsag_pkg::STEP_IN_W-1:0];
				end
				mcsag_pkg::CFG_POLE_PAIR: begin
					cfg_q.pole_pairs <= cfg_data[mcsag_pkg::PP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/mcsag_ctrl.sv]
module mcsag_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mcsag_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_ZSEQ,
		S_MUL,
		S_ACC,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [mcsag_pkg::PH_W-1:0]   ph_q;
	logic                         out_valid_q;
	logic                         accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd          = '0;
		cmd.sel      = ph_q;
		cmd.load     = accept;
		cmd.sum_en   = (state_q == S_SUM);
		cmd.zseq_en  = (state_q == S_ZSEQ);
		cmd.mul_en   = (state_q == S_MUL);
		cmd.acc_en   = (state_q == S_ACC);
		cmd.out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	// Sequencer: sum, zero-sequence removal, then one multiply and one
	// accumulate per phase, then hand over to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_ZSEQ;
				end
				S_ZSEQ: begin
					ph_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (ph_q == mcsag_pkg::PH_W'(mcsag_pkg::NUM_PH - 1)) begin
						state_q <= S_DONE;
					end else begin
						ph_q    <= ph_q + mcsag_pkg::PH_W'(1);
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A finished result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// An accepted request always starts the sum step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SUM))
		else $error("accepted request did not start processing");

	// The phase counter never selects a phase beyond the last one.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_en || cmd.acc_en) |->
		(ph_q < mcsag_pkg::PH_W'(mcsag_pkg::NUM_PH)))
		else $error("phase select out of range");

	// Each accumulate follows the multiply of the same phase.
	a_mul_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_en |-> ($past(cmd.mul_en) && $stable(ph_q)))
		else $error("accumulate without matching multiply");
`endif

endmodule

[design/mcsag_dpath.sv]
module mcsag_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcsag_pkg::ctrl_cmd_t                   cmd,
	input  mcsag_pkg::cfg_t                        cfg,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_u,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_v,
	input  logic [mcsag_pkg::ADC_BITS-1:0]         sample_w,
	input  logic                                   open_loop_mode,
	input  logic [mcsag_pkg::STEP_IN_W-1:0]        hall_angle_step,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_u,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_v,
	output logic signed [mcsag_pkg::CUR_W-1:0]     current_w,
	output logic [mcsag_pkg::ANGLE_BITS-1:0]       electrical_angle
);

	localparam int DIFF_W = mcsag_pkg::DIFF_W;
	localparam int SUM_W  = mcsag_pkg::SUM_W;
	localparam int X_W    = mcsag_pkg::X_W;
	localparam int ERR_W  = mcsag_pkg::ERR_W;
	localparam int PROD_W = mcsag_pkg::PROD_W;
	localparam int RND_W  = mcsag_pkg::RND_W;
	localparam int ACC_W  = mcsag_pkg::ACC_W;
	localparam int CUR_W  = mcsag_pkg::CUR_W;
	localparam int DIV_W  = mcsag_pkg::DIV_W;
	localparam int DIV_K  = mcsag_pkg::DIV_K;
	localparam int ANG_W  = mcsag_pkg::ANGLE_BITS;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (CUR_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(2 ** (CUR_W - 1));

	logic signed [DIFF_W-1:0]        d_q [mcsag_pkg::NUM_PH];
	logic signed [X_W-1:0]           x_q [mcsag_pkg::NUM_PH];
	logic signed [CUR_W-1:0]         f_q [mcsag_pkg::NUM_PH];
	logic                            mode_q;
	logic [mcsag_pkg::STEP_IN_W-1:0] hstep_q;
	logic signed [SUM_W-1:0]         s_q;
	logic [DIV_W-1:0]                q_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic [ANG_W-1:0]                mech_q;
	logic [ANG_W-1:0]                hall_q;
	logic [ANG_W-1:0]                elec_q;
	logic signed [CUR_W-1:0]         cur_u_q;
	logic signed [CUR_W-1:0]         cur_v_q;
	logic signed [CUR_W-1:0]         cur_w_q;
	logic [ANG_W-1:0]                elec_out_q;

	logic signed [SUM_W-1:0]         sum;
	logic [DIV_W-1:0]                div_u;
	logic [DIV_W+DIV_K-1:0]          div_p;
	logic signed [X_W-1:0]           s_x;
	logic signed [X_W-1:0]           zs;
	logic signed [X_W-1:0]           z;
	logic signed [ERR_W-1:0]         err;
	logic signed [PROD_W-1:0]        prod_rnd;
	logic signed [RND_W-1:0]         step;
	logic signed [ACC_W-1:0]         acc;
	logic signed [CUR_W-1:0]         f_sat;
	logic [ANG_W-1:0]                mech_new;
	logic [ANG_W+mcsag_pkg::PP_W-1:0] elec_p;

	// Sum of the three offset-corrected samples and its third, by reciprocal.
	always_comb begin
		sum   = SUM_W'(d_q[0]) + SUM_W'(d_q[1]) + SUM_W'(d_q[2]);
		div_u = DIV_W'(sum) + DIV_W'(1) + DIV_W'(mcsag_pkg::DIV_BIAS);
		div_p = (DIV_W + DIV_K)'(div_u) * (DIV_W + DIV_K)'(mcsag_pkg::DIV_M);
	end

	// Zero-sequence term: round(256 * sum / 3) = 85 * sum + floor((sum + 1) / 3).
	always_comb begin
		s_x = X_W'(s_q);
		zs  = s_x * $signed(X_W'(mcsag_pkg::ZS_MUL));
		z   = zs + $signed(X_W'(q_q)) - $signed(X_W'(mcsag_pkg::Q_BIAS));
	end

	// Filter error and rounded update of the selected phase.
	always_comb begin
		err      = ERR_W'(x_q[cmd.sel]) - ERR_W'(f_q[cmd.sel]);
		prod_rnd = prod_q + PROD_W'(2 ** (mcsag_pkg::ALPHA_W - 1));
		step     = RND_W'(prod_rnd >>> mcsag_pkg::ALPHA_W);
		acc      = ACC_W'(f_q[cmd.sel]) + ACC_W'(step);
		if (acc > SAT_MAX) begin
			f_sat = SAT_MAX[CUR_W-1:0];
		end else if (acc < SAT_MIN) begin
			f_sat = SAT_MIN[CUR_W-1:0];
		end else begin
			f_sat = acc[CUR_W-1:0];
		end
	end

	// Open-loop angle and its electrical multiple.
	always_comb begin
		mech_new = mech_q + ANG_W'(cfg.ol_step);
		elec_p   = (ANG_W + mcsag_pkg::PP_W)'(mech_new) *
			(ANG_W + mcsag_pkg::PP_W)'(cfg.pole_pairs);
	end

	// Working registers of the request in flight.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q[0]  <= $signed({1'b0, sample_u}) - $signed({1'b0, cfg.offset_u});
			d_q[1]  <= $signed({1'b0, sample_v}) - $signed({1'b0, cfg.offset_v});
			d_q[2]  <= $signed({1'b0, sample_w}) - $signed({1'b0, cfg.offset_w});
			mode_q  <= open_loop_mode;
			hstep_q <= hall_angle_step;
		end
		if (cmd.sum_en) begin
			s_q <= sum;
			q_q <= div_p[DIV_W+DIV_K-1:DIV_K];
		end
		if (cmd.zseq_en) begin
			for (int i = 0; i < mcsag_pkg::NUM_PH; i++) begin
				x_q[i] <= (X_W'(d_q[i]) <<< mcsag_pkg::FRAC_BITS) - z;
			end
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(err) * PROD_W'($signed({1'b0, cfg.alpha}));
		end
		if (cmd.out_load) begin
			cur_u_q    <= f_q[0];
			cur_v_q    <= f_q[1];
			cur_w_q    <= f_q[2];
			elec_out_q <= elec_q;
		end
	end

	// Filter and angle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcsag_pkg::NUM_PH; i++) begin
				f_q[i] <= '0;
			end
			mech_q <= '0;
			hall_q <= '0;
			elec_q <= '0;
		end else begin
			if (cmd.acc_en) begin
				f_q[cmd.sel] <= f_sat;
			end
			if (cmd.sum_en) begin
				if (mode_q) begin
					mech_q <= mech_new;
					elec_q <= elec_p[ANG_W-1:0];
				end else begin
					hall_q <= hall_q + ANG_W'(hstep_q);
					elec_q <= hall_q + ANG_W'(hstep_q);
				end
			end
		end
	end

	assign current_u        = cur_u_q;
	assign current_v        = cur_v_q;
	assign current_w        = cur_w_q;
	assign electrical_angle = elec_out_q;

endmodule

[verif/motor_current_sense_angle_gen_unit_tb.sv]
module motor_current_sense_angle_gen_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcsag_pkg::*;

	localparam int     MAX_REPORTS      = 10;
	localparam int     SETTLE_CYCLES    = 24;
	localparam int     HOLD_CYCLES      = 300;
	localparam int     RANDOM_PER_PHASE = 110;
	localparam int     PRESSURE_ITEMS   = 60;
	localparam int     RUN_LIMIT        = 200000;
	localparam longint CUR_HI           = (longint'(1) <<< (CUR_W - 1)) - 1;
	localparam longint CUR_LO           = -(longint'(1) <<< (CUR_W - 1));

	typedef struct {
		logic [ADC_BITS-1:0]  sample_u;
		logic [ADC_BITS-1:0]  sample_v;
		logic [ADC_BITS-1:0]  sample_w;
		logic                 open_loop;
		logic [STEP_IN_W-1:0] hall_step;
	} sense_request_t;

	typedef struct {
		logic signed [CUR_W-1:0] current_u;
		logic signed [CUR_W-1:0] current_v;
		logic signed [CUR_W-1:0] current_w;
		logic [ANGLE_BITS-1:0]   angle;
	} phase_reading_t;

	// Predicts the conditioned currents and the angle, and checks the readings in order.
	class current_angle_scoreboard;
		logic [ADC_BITS-1:0]     offset_u     = OFFSET_RST;
		logic [ADC_BITS-1:0]     offset_v     = OFFSET_RST;
		logic [ADC_BITS-1:0]     offset_w     = OFFSET_RST;
		logic [ALPHA_W-1:0]      alpha        = ALPHA_RST;
		logic [STEP_IN_W-1:0]    ol_step      = OL_STEP_RST;
		logic [PP_W-1:0]         pole_pairs   = PP_RST;
		logic [ANGLE_BITS-1:0]   forced_angle = '0;
		logic [ANGLE_BITS-1:0]   hall_angle   = '0;
		logic signed [CUR_W-1:0] filt_u       = '0;
		logic signed [CUR_W-1:0] filt_v       = '0;
		logic signed [CUR_W-1:0] filt_w       = '0;
		phase_reading_t          expected_readings[$];
		int                      mismatches   = 0;

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_OFFSET_U:  offset_u = data;
				CFG_OFFSET_V:  offset_v = data;
				CFG_OFFSET_W:  offset_w = data;
				CFG_ALPHA:     alpha = data;
				CFG_OL_STEP:   ol_step = data;
				CFG_POLE_PAIR: pole_pairs = data[PP_W-1:0];
				default:       ;
			endcase
		endfunction

		// First-order low-pass step with rounding half up, saturated to the current range.
		function logic signed [CUR_W-1:0] smooth(logic signed [CUR_W-1:0] f, longint x);
			longint acc;
			acc = longint'(f) + (((x - longint'(f)) * longint'(alpha) + 64'sd32768) >>> 16);
			if (acc > CUR_HI) acc = CUR_HI;
			else if (acc < CUR_LO) acc = CUR_LO;
			return acc[CUR_W-1:0];
		endfunction

		function void note_request(sense_request_t r);
			longint         du;
			longint         dv;
			longint         dw;
			longint         zs_num;
			longint         zs;
			phase_reading_t want;
			du = longint'(r.sample_u) - longint'(offset_u);
			dv = longint'(r.sample_v) - longint'(offset_v);
			dw = longint'(r.sample_w) - longint'(offset_w);
			// Only the angle of the active mode moves; the other one is held.
			if (r.open_loop) begin
				forced_angle = forced_angle + ol_step;
				want.angle = forced_angle * pole_pairs;
			end else begin
				hall_angle = hall_angle + r.hall_step;
				want.angle = hall_angle;
			end
			// Zero-sequence mean in counts with 8 fraction bits, rounded to nearest.
			zs_num = (du + dv + dw) * 512 + 3;
			zs = zs_num / 6;
			if (zs_num % 6 != 0 && zs_num < 0) zs = zs - 1;
			filt_u = smooth(filt_u, du * 256 - zs);
			filt_v = smooth(filt_v, dv * 256 - zs);
			filt_w = smooth(filt_w, dw * 256 - zs);
			want.current_u = filt_u;
			want.current_v = filt_v;
			want.current_w = filt_w;
			expected_readings.push_back(want);
		endfunction

		function void check_result(phase_reading_t got);
			phase_reading_t want;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected reading %0d %0d %0d angle %0d", $time,
						got.current_u, got.current_v, got.current_w, got.angle);
				return;
			end
			want = expected_readings.pop_front();
			if (got.current_u !== want.current_u || got.current_v !== want.current_v ||
					got.current_w !== want.current_w || got.angle !== want.angle) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: reading %0d %0d %0d angle %0d, expected %0d %0d %0d angle %0d",
						$time, got.current_u, got.current_v, got.current_w, got.angle,
						want.current_u, want.current_v, want.current_w, want.angle);
			end
		endfunction
	endclass

	logic                     clk             = 1'b0;
	logic                     arst_n          = 1'b0;
	logic                     in_valid        = 1'b0;
	logic                     in_ready;
	logic [ADC_BITS-1:0]      sample_u        = '0;
	logic [ADC_BITS-1:0]      sample_v        = '0;
	logic [ADC_BITS-1:0]      sample_w        = '0;
	logic                     open_loop_mode  = 1'b0;
	logic [STEP_IN_W-1:0]     hall_angle_step = '0;
	logic                     out_valid;
	logic                     out_ready       = 1'b0;
	logic signed [CUR_W-1:0]  current_u;
	logic signed [CUR_W-1:0]  current_v;
	logic signed [CUR_W-1:0]  current_w;
	logic [ANGLE_BITS-1:0]    electrical_angle;
	logic                     cfg_valid       = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index       = '0;
	logic [CFG_DATA_W-1:0]    cfg_data        = '0;

	current_angle_scoreboard  sb              = new();
	int                       stall_pct       = 0;
	logic                     hold_off        = 1'b0;
	logic                     ol_run          = 1'b0;
	int                       cycle_count     = 0;
	int                       send_idle_pct[4] = '{0, 66, 0, 22};
	int                       recv_stall_pct[4] = '{0, 0, 66, 22};

	motor_current_sense_angle_gen_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample_u         (sample_u),
		.sample_v         (sample_v),
		.sample_w         (sample_w),
		.open_loop_mode   (open_loop_mode),
		.hall_angle_step  (hall_angle_step),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.current_u        (current_u),
		.current_v        (current_v),
		.current_w        (current_w),
		.electrical_angle (electrical_angle),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: check every accepted reading and stall at random or during a hold-off.
	always @(posedge clk) begin
		phase_reading_t got;
		if (out_valid && out_ready) begin
			got.current_u = current_u;
			got.current_v = current_v;
			got.current_w = current_w;
			got.angle = electrical_angle;
			sb.check_result(got);
		end
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	function automatic sense_request_t make_request(logic [ADC_BITS-1:0] u,
			logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] w, logic ol,
			logic [STEP_IN_W-1:0] step);
		sense_request_t r;
		r.sample_u = u;
		r.sample_v = v;
		r.sample_w = w;
		r.open_loop = ol;
		r.hall_step = step;
		return r;
	endfunction

	// Samples are close to the zero-current count half of the time, otherwise rails or full-range noise.
	function automatic logic [ADC_BITS-1:0] pick_sample(logic [ADC_BITS-1:0] centre);
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2, 3:    return ADC_BITS'($urandom);
			default: return centre + ADC_BITS'($urandom_range(4095)) - ADC_BITS'(2048);
		endcase
	endfunction

	// The mode runs in stretches, switching now and then.
	function automatic sense_request_t random_request();
		sense_request_t r;
		if ($urandom_range(11) == 0) ol_run = !ol_run;
		r.sample_u = pick_sample(sb.offset_u);
		r.sample_v = pick_sample(sb.offset_v);
		r.sample_w = pick_sample(sb.offset_w);
		r.open_loop = ol_run;
		case ($urandom_range(7))
			0:       r.hall_step = '0;
			1:       r.hall_step = '1;
			default: r.hall_step = STEP_IN_W'($urandom);
		endcase
		return r;
	endfunction

	function automatic logic [ADC_BITS-1:0] random_offset();
		if ($urandom_range(3) == 0) return ADC_BITS'($urandom);
		return OFFSET_RST + ADC_BITS'($urandom_range(4095)) - ADC_BITS'(2048);
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.offset_u = random_offset();
		c.offset_v = random_offset();
		c.offset_w = random_offset();
		case ($urandom_range(7))
			0:       c.alpha = '1;
			1:       c.alpha = ALPHA_W'(1);
			default: c.alpha = ALPHA_W'($urandom_range(65535, 1));
		endcase
		c.ol_step = STEP_IN_W'($urandom);
		if ($urandom_range(3) == 0) c.pole_pairs = PP_W'($urandom);
		else c.pole_pairs = PP_W'($urandom_range(16, 1));
		return c;
	endfunction

	// Offer one request, after a random idle gap, and hold it until it is taken.
	task automatic send_request(sense_request_t r, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_u <= r.sample_u;
		sample_v <= r.sample_v;
		sample_w <= r.sample_w;
		open_loop_mode <= r.open_loop;
		hall_angle_step <= r.hall_step;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic drive_requests(int count, int idle_pct);
		for (int i = 0; i < count; i++)
			send_request(random_request(), idle_pct);
	endtask

	// Stop offering, let every reading come out, then allow the block to settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic post_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, data);
	endtask

	// Write every register; the upper bits of the pole-pair word are junk on purpose.
	task automatic apply_settings(cfg_t c, bit poke_spare);
		post_register(CFG_OFFSET_U, c.offset_u);
		post_register(CFG_OFFSET_V, c.offset_v);
		post_register(CFG_OFFSET_W, c.offset_w);
		post_register(CFG_ALPHA, c.alpha);
		post_register(CFG_OL_STEP, c.ol_step);
		post_register(CFG_POLE_PAIR, {(CFG_DATA_W - PP_W)'($urandom), c.pole_pairs});
		if (poke_spare)
			for (int k = int'(CFG_POLE_PAIR) + 1; k < 2 ** CFG_IDX_W; k++)
				post_register(CFG_IDX_W'(k), '1);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		cfg_t c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero current, rails, both modes and switching between them.
		send_request(make_request(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000), 0);
		send_request(make_request(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'hFFFF), 0);
		send_request(make_request(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000), 0);
		send_request(make_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h1234), 0);
		send_request(make_request(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0001), 0);
		send_request(make_request(16'd12345, 16'd40000, 16'd50000, 1'b0, 16'h8000), 0);
		send_request(make_request(16'h7FFF, 16'h8001, 16'h8000, 1'b1, 16'hAAAA), 0);
		wait_idle();

		// Extreme offsets, the fastest filter, the largest step and the widest pole-pair word.
		c = '{offset_u: '0, offset_v: '1, offset_w: '0, alpha: '1, ol_step: '1,
			pole_pairs: '1};
		apply_settings(c, 1'b1);
		send_request(make_request(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 16'h5555), 0);
		send_request(make_request(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000), 0);
		send_request(make_request(16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'h8001), 0);
		send_request(make_request(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'hFFFF), 0);
		send_request(make_request(16'h8000, 16'h4000, 16'hC000, 1'b1, 16'h0000), 0);
		send_request(make_request(16'h0001, 16'hFFFE, 16'h0001, 1'b0, 16'h7FFF), 0);
		wait_idle();

		// A frozen filter and zero pole pairs, so the forced angle reads zero.
		c = '{offset_u: '1, offset_v: '0, offset_w: '1, alpha: '0, ol_step: 16'd1000,
			pole_pairs: '0};
		apply_settings(c, 1'b0);
		send_request(make_request(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000), 0);
		send_request(make_request(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 16'h0000), 0);
		send_request(make_request(16'h1234, 16'h5678, 16'h9ABC, 1'b0, 16'h0100), 0);
		send_request(make_request(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF), 0);
		wait_idle();

		// The slowest filter with the largest pole-pair count in range.
		c = '{offset_u: OFFSET_RST, offset_v: OFFSET_RST, offset_w: OFFSET_RST,
			alpha: ALPHA_W'(1), ol_step: STEP_IN_W'(1), pole_pairs: PP_W'(16)};
		apply_settings(c, 1'b0);
		send_request(make_request(16'hFFFF, 16'h8000, 16'h0000, 1'b1, 16'h0000), 0);
		send_request(make_request(16'h0000, 16'h8000, 16'hFFFF, 1'b1, 16'h0000), 0);
		send_request(make_request(16'h9000, 16'h7000, 16'h8000, 1'b0, 16'h00FF), 0);

		// Random requests under each idling pattern, with fresh settings every time.
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			apply_settings(random_settings(), 1'b0);
			stall_pct <= recv_stall_pct[p];
			drive_requests(RANDOM_PER_PHASE, send_idle_pct[p]);
		end

		// Hold the result side off for a long stretch so that the input backs up.
		wait_idle();
		apply_settings(random_settings(), 1'b0);
		stall_pct <= 0;
		fork
			drive_requests(PRESSURE_ITEMS, 0);
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join
		wait_idle();

		if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
